@@ hw/rtl/radse_pkg.sv @@
package radse_pkg;

	localparam int OPT_START  = 16;
	localparam int RA_TYPE    = 134;
	localparam int RDNSS_TYPE = 25;
	localparam int HOP_REQ    = 255;

	localparam logic KIND_ADDR   = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	// packet status codes; among the fault codes 2 to 8 the lower code wins
	localparam logic [3:0] ST_FOUND       = 4'd0;
	localparam logic [3:0] ST_NONE        = 4'd1;
	localparam logic [3:0] ST_NO_IFACE    = 4'd2;
	localparam logic [3:0] ST_OTHER_IFACE = 4'd3;
	localparam logic [3:0] ST_NO_HOP      = 4'd4;
	localparam logic [3:0] ST_SHORT       = 4'd5;
	localparam logic [3:0] ST_NOT_RA      = 4'd6;
	localparam logic [3:0] ST_BAD_CODE    = 4'd7;
	localparam logic [3:0] ST_NOT_LL      = 4'd8;

	typedef struct packed {
		logic        source_link_local;
		logic        hop_limit_known;
		logic [7:0]  hop_limit;
		logic [15:0] arrival_interface;
		logic        last_byte;
		logic [7:0]  data_byte;
	} radse_item_t;

	typedef struct packed {
		logic        last_result;
		logic [7:0]  server_count;
		logic [3:0]  packet_status;
		logic [31:0] server_lifetime;
		logic [63:0] server_addr_low;
		logic [63:0] server_addr_high;
		logic        result_kind;
	} radse_res_t;

endpackage

@@ hw/rtl/radse_parse.sv @@
module radse_parse #(
	parameter int MAX_PACKET_BYTES = 2048
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [15:0]         expected_interface,
	input  logic                in_valid,
	output logic                in_ready,
	input  radse_pkg::radse_item_t in_item,
	input  logic                room,
	output logic [1:0]          push_n,
	output radse_pkg::radse_res_t res0,
	output radse_pkg::radse_res_t res1
);
	import radse_pkg::*;

	localparam int OW = $clog2(MAX_PACKET_BYTES + 1);
	localparam int NW = $clog2(MAX_PACKET_BYTES + 2040);

	logic        v_s1;
	radse_item_t item_s1;
	logic        go;

	logic [OW-1:0]  off_q, off_d;
	logic [NW-1:0]  nxt_q, nxt_d;
	logic [NW-1:0]  end_q, end_d;
	logic [OW-1:0]  start_q, start_d;
	logic           sized_q, sized_d;
	logic [7:0]     otype_q, otype_d;
	logic [31:0]    olife_q, olife_d;
	logic [31:0]    llife_q, llife_d;
	logic [127:0]   shift_q, shift_d;
	logic [3:0]     acnt_q, acnt_d;
	logic [3:0]     rej_q, rej_d;
	logic           stop_q, stop_d;
	logic [7:0]     found_q, found_d;

	logic [OW-1:0]  o;
	logic [OW-1:0]  rel;
	logic [7:0]     b;
	logic           emit;
	logic [3:0]     c0;
	logic [3:0]     status;
	radse_res_t     addr_res;
	radse_res_t     stat_res;

	assign go       = v_s1 && room;
	assign in_ready = !v_s1 || room;

	always_comb begin
		off_d   = off_q;
		nxt_d   = nxt_q;
		end_d   = end_q;
		start_d = start_q;
		sized_d = sized_q;
		otype_d = otype_q;
		olife_d = olife_q;
		llife_d = llife_q;
		shift_d = shift_q;
		acnt_d  = acnt_q;
		rej_d   = rej_q;
		stop_d  = stop_q;
		found_d = found_q;
		emit    = 1'b0;
		o       = off_q;
		b       = item_s1.data_byte;
		rel     = o - start_q;
		c0      = ST_FOUND;

		if (off_q < OW'(MAX_PACKET_BYTES)) begin
			if (o == '0) begin
				// first fault in priority order is the lowest code
				if (item_s1.arrival_interface == 16'd0)
					c0 = ST_NO_IFACE;
				else if (item_s1.arrival_interface != expected_interface)
					c0 = ST_OTHER_IFACE;
				else if (!item_s1.hop_limit_known)
					c0 = ST_NO_HOP;
				else if (b != 8'(RA_TYPE))
					c0 = ST_NOT_RA;
				else if (item_s1.hop_limit != 8'(HOP_REQ))
					c0 = ST_BAD_CODE;
				else if (!item_s1.source_link_local)
					c0 = ST_NOT_LL;
				rej_d = c0;
			end else if (o == OW'(1)) begin
				if (b != 8'd0 && (rej_q == ST_FOUND || rej_q == ST_NOT_LL))
					rej_d = ST_BAD_CODE;
			end else if (o >= OW'(OPT_START) && rej_q == ST_FOUND && !stop_q) begin
				if (NW'(o) == nxt_q) begin
					start_d = o;
					otype_d = b;
					sized_d = 1'b0;
					acnt_d  = '0;
					shift_d = '0;
					olife_d = '0;
				end else if (!sized_q) begin
					if (o == start_q + OW'(1)) begin
						if (b == 8'd0) begin
							stop_d = 1'b1;
						end else begin
							end_d   = NW'(start_q) + NW'({b, 3'b000});
							nxt_d   = NW'(start_q) + NW'({b, 3'b000});
							sized_d = 1'b1;
						end
					end
				end else if (otype_q == 8'(RDNSS_TYPE) && NW'(o) < end_q) begin
					if (rel >= OW'(4) && rel < OW'(8)) begin
						olife_d = {olife_q[23:0], b};
						if (rel == OW'(7))
							llife_d = {olife_q[23:0], b};
					end else if (rel >= OW'(8)) begin
						shift_d = {shift_q[119:0], b};
						acnt_d  = acnt_q + 4'd1;
						if (acnt_q == 4'd15) begin
							emit = 1'b1;
							if (found_q != 8'hFF)
								found_d = found_q + 8'd1;
						end
					end
				end
			end
			off_d = off_q + OW'(1);
		end

		if (rej_d >= ST_NO_IFACE && rej_d <= ST_NO_HOP)
			status = rej_d;
		else if (off_d < OW'(OPT_START))
			status = ST_SHORT;
		else if (rej_d != ST_FOUND)
			status = rej_d;
		else
			status = (found_d != 8'd0) ? ST_FOUND : ST_NONE;

		addr_res.result_kind      = KIND_ADDR;
		addr_res.server_addr_high = shift_d[127:64];
		addr_res.server_addr_low  = shift_d[63:0];
		addr_res.server_lifetime  = olife_q;
		addr_res.packet_status    = ST_FOUND;
		addr_res.server_count     = found_d;
		addr_res.last_result      = !item_s1.last_byte;

		stat_res.result_kind      = KIND_STATUS;
		stat_res.server_addr_high = '0;
		stat_res.server_addr_low  = '0;
		stat_res.server_lifetime  = llife_d;
		stat_res.packet_status    = status;
		stat_res.server_count     = found_d;
		stat_res.last_result      = 1'b1;

		res0 = emit ? addr_res : stat_res;
		res1 = stat_res;
		if (!go)
			push_n = 2'd0;
		else
			push_n = 2'(emit) + 2'(item_s1.last_byte);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			item_s1 <= in_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q   <= '0;
			nxt_q   <= NW'(OPT_START);
			end_q   <= '0;
			start_q <= '0;
			sized_q <= 1'b0;
			otype_q <= '0;
			olife_q <= '0;
			llife_q <= '1;
			shift_q <= '0;
			acnt_q  <= '0;
			rej_q   <= ST_FOUND;
			stop_q  <= 1'b0;
			found_q <= '0;
		end else if (go) begin
			if (item_s1.last_byte) begin
				// packet end: back to the idle packet state
				off_q   <= '0;
				nxt_q   <= NW'(OPT_START);
				end_q   <= '0;
				start_q <= '0;
				sized_q <= 1'b0;
				otype_q <= '0;
				olife_q <= '0;
				llife_q <= '1;
				shift_q <= '0;
				acnt_q  <= '0;
				rej_q   <= ST_FOUND;
				stop_q  <= 1'b0;
				found_q <= '0;
			end else begin
				off_q   <= off_d;
				nxt_q   <= nxt_d;
				end_q   <= end_d;
				start_q <= start_d;
				sized_q <= sized_d;
				otype_q <= otype_d;
				olife_q <= olife_d;
				llife_q <= llife_d;
				shift_q <= shift_d;
				acnt_q  <= acnt_d;
				rej_q   <= rej_d;
				stop_q  <= stop_d;
				found_q <= found_d;
			end
		end
	end

	a_off_bound: assert property (@(posedge clk) disable iff (!arst_n)
		off_q <= OW'(MAX_PACKET_BYTES))
		else $error("byte offset ran past the packet limit");

	a_walk_only_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(go && rej_q != ST_FOUND) |-> !emit)
		else $error("address emitted from a rejected packet");

	a_last_pushes: assert property (@(posedge clk) disable iff (!arst_n)
		(go && item_s1.last_byte) |-> (push_n != 2'd0))
		else $error("packet end produced no status");

endmodule

@@ hw/rtl/radse_outq.sv @@
module radse_outq (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [1:0]            push_n,
	input  radse_pkg::radse_res_t push0,
	input  radse_pkg::radse_res_t push1,
	output logic                  room,
	output logic                  out_valid,
	input  logic                  out_ready,
	output radse_pkg::radse_res_t out_res
);
	import radse_pkg::*;

	localparam int DEPTH = 4;
	localparam int PW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);

	radse_res_t    mem_q [DEPTH];
	logic [PW-1:0] wp_q;
	logic [PW-1:0] rp_q;
	logic [CW-1:0] cnt_q;
	logic          pop;

	// a request may queue two results, so keep two slots free
	assign room      = cnt_q <= CW'(DEPTH - 2);
	assign out_valid = cnt_q != '0;
	assign out_res   = mem_q[rp_q];
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push_n != 2'd0)
			mem_q[wp_q] <= push0;
		if (push_n == 2'd2)
			mem_q[wp_q + PW'(1)] <= push1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + PW'(push_n);
			if (pop)
				rp_q <= rp_q + PW'(1);
			cnt_q <= cnt_q + CW'(push_n) - CW'(pop);
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("result queue count out of range");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push_n != 2'd0) |-> (cnt_q + CW'(push_n) - CW'(pop) <= CW'(DEPTH)))
		else $error("result queue overflow");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == CW'(1) && pop && push_n == 2'd0) |=> !out_valid)
		else $error("result queue did not empty");

endmodule

@@ hw/rtl/router_advert_dns_server_extractor_unit.sv @@
// router advertisement dns server extractor
// s_axis carries an icmpv6 router advertisement one byte per request, starting
// at the icmp type byte; tlast marks the packet's final byte. the per-packet
// metadata (arrival interface, hop limit, flags) is taken from the first byte.
// m_axis returns results: a dns server address with its option lifetime
// (tuser 0), and on the packet's last byte an end-of-packet status (tuser 1).
// m_axis tlast marks the final result caused by one input byte.
// cfg_we/cfg_wdata set the accepted interface index; write it only while idle.
// a byte is registered at the input stage, then written into the result queue.
// throughput: one byte per cycle while the queue has room; the per-byte offset
// compare and shift sit between the input register and the four-entry result
// queue. a last byte that also completes an address queues two results.
// when m_axis stalls the queue fills and s_axis_tready drops once fewer than
// two slots remain; nothing is lost.
// reset clears the packet state and sets the interface index to zero.
module router_advert_dns_server_extractor_unit #(
	parameter int MAX_PACKET_BYTES = 2048
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [15:0]  cfg_wdata,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// data_byte, arrival_interface, hop_limit
	input  logic [31:0]  s_axis_tdata,
	input  logic         s_axis_tlast,
	// hop_limit_known, source_link_local
	input  logic [1:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// server_addr_high, server_addr_low, server_lifetime, packet_status,
	// server_count, zero fill
	output logic [175:0] m_axis_tdata,
	output logic         m_axis_tlast,
	// result_kind
	output logic         m_axis_tuser
);
	import radse_pkg::*;

	logic [15:0] exp_iface_q;
	radse_item_t in_item;
	radse_res_t  res0;
	radse_res_t  res1;
	radse_res_t  out_res;
	logic [1:0]  push_n;
	logic        room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_iface_q <= '0;
		end else if (cfg_we) begin
			exp_iface_q <= cfg_wdata;
		end
	end

	assign in_item.data_byte         = s_axis_tdata[7:0];
	assign in_item.arrival_interface = s_axis_tdata[23:8];
	assign in_item.hop_limit         = s_axis_tdata[31:24];
	assign in_item.last_byte         = s_axis_tlast;
	assign in_item.hop_limit_known   = s_axis_tuser[0];
	assign in_item.source_link_local = s_axis_tuser[1];

	radse_parse #(
		.MAX_PACKET_BYTES(MAX_PACKET_BYTES)
	) u_parse (
		.clk               (clk),
		.arst_n            (arst_n),
		.expected_interface(exp_iface_q),
		.in_valid          (s_axis_tvalid),
		.in_ready          (s_axis_tready),
		.in_item           (in_item),
		.room              (room),
		.push_n            (push_n),
		.res0              (res0),
		.res1              (res1)
	);

	radse_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_n   (push_n),
		.push0    (res0),
		.push1    (res1),
		.room     (room),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_res  (out_res)
	);

	assign m_axis_tdata = {4'b0000, out_res.server_count, out_res.packet_status,
		out_res.server_lifetime, out_res.server_addr_low, out_res.server_addr_high};
	assign m_axis_tlast = out_res.last_result;
	assign m_axis_tuser = out_res.result_kind;

endmodule
